// ----- hdl/rss_pkg.sv -----
// shared record types and command codes for the record selection sort block
package rss_pkg;

  localparam int unsigned KeyW    = 24;
  localparam int unsigned TagW    = 16;
  localparam int unsigned EnrollW = 10;

  // one stored record: key plus payload
  typedef struct packed {
    logic [KeyW-1:0]    key;
    logic [TagW-1:0]    tag;
    logic [EnrollW-1:0] cur_enroll;
    logic [EnrollW-1:0] max_enroll;
    logic [EnrollW-1:0] waitlist;
    logic               online;
  } rec_t;

  // write port source select
  typedef enum logic [1:0] {
    WR_NONE = 2'd0,
    WR_LOAD = 2'd1,
    WR_BEST = 2'd2,
    WR_POS  = 2'd3
  } wr_sel_e;

  // controller to datapath commands
  typedef struct packed {
    logic    rd_en;
    logic    ld_pass;
    logic    cmp_en;
    wr_sel_e wr_sel;
    logic    emit;
    logic    last;
  } dp_cmd_t;

endpackage

// ----- hdl/record_selection_sort.sv -----
// top level of the record selection sort block
//
//   channel  | handshake               | payload
//   ---------+-------------------------+--------------------------------------
//   input    | start_i, busy_o         | key_i, record_tag_i, cur_enroll_i,
//            |                         | max_enroll_i, waitlist_i, online_i,
//            |                         | last_i
//   result   | out_valid_o (strobe)    | sorted_key_o, out_tag_o, ...,
//            |                         | out_online_o, out_last_o
//
// a beat without last leaves busy_o low.
// after a last beat, busy_o stays high while the stored set is sorted and
// emitted: each pass reads and compares one record at a time through the
// single read port of the record memory, then swaps in two writes; emission
// reads each record and then gives it out.
// reset clears the controller only; the record memory is not cleared.
// the receiver cannot stall: each strobe lasts one cycle.
module record_selection_sort #(
  parameter int unsigned DEPTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [23:0] key_i,
  input  logic [15:0] record_tag_i,
  input  logic [9:0]  cur_enroll_i,
  input  logic [9:0]  max_enroll_i,
  input  logic [9:0]  waitlist_i,
  input  logic        online_i,
  input  logic        last_i,
  output logic        out_valid_o,
  output logic [23:0] sorted_key_o,
  output logic [15:0] out_tag_o,
  output logic [9:0]  out_cur_enroll_o,
  output logic [9:0]  out_max_enroll_o,
  output logic [9:0]  out_waitlist_o,
  output logic        out_online_o,
  output logic        out_last_o
);

  localparam int unsigned AW = $clog2(DEPTH);

  rss_pkg::dp_cmd_t cmd;
  rss_pkg::rec_t    in_rec;
  rss_pkg::rec_t    rd_rec;
  logic [AW-1:0]    rd_addr;
  logic [AW-1:0]    wr_addr;
  logic [AW-1:0]    idx;

  // incoming beat as a record
  assign in_rec.key        = key_i;
  assign in_rec.tag        = record_tag_i;
  assign in_rec.cur_enroll = cur_enroll_i;
  assign in_rec.max_enroll = max_enroll_i;
  assign in_rec.waitlist   = waitlist_i;
  assign in_rec.online     = online_i;

  rss_ctrl #(
    .DEPTH(DEPTH)
  ) u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .last_i   (last_i),
    .busy_o   (busy_o),
    .cmd_o    (cmd),
    .rd_addr_o(rd_addr),
    .wr_addr_o(wr_addr),
    .idx_o    (idx)
  );

  rss_datapath #(
    .DEPTH(DEPTH)
  ) u_dp (
    .clk_i    (clk_i),
    .cmd_i    (cmd),
    .rd_addr_i(rd_addr),
    .wr_addr_i(wr_addr),
    .idx_i    (idx),
    .in_rec_i (in_rec),
    .rd_rec_o (rd_rec)
  );

  // result beat
  assign out_valid_o      = cmd.emit;
  assign out_last_o       = cmd.last;
  assign sorted_key_o     = rd_rec.key;
  assign out_tag_o        = rd_rec.tag;
  assign out_cur_enroll_o = rd_rec.cur_enroll;
  assign out_max_enroll_o = rd_rec.max_enroll;
  assign out_waitlist_o   = rd_rec.waitlist;
  assign out_online_o     = rd_rec.online;

endmodule

// ----- hdl/rss_datapath.sv -----
// record memory, best-candidate registers and key compare
module rss_datapath #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  rss_pkg::dp_cmd_t cmd_i,
  input  logic [AW-1:0]    rd_addr_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [AW-1:0]    idx_i,
  input  rss_pkg::rec_t    in_rec_i,
  output rss_pkg::rec_t    rd_rec_o
);

  rss_pkg::rec_t mem_q [DEPTH];
  rss_pkg::rec_t rd_q;
  rss_pkg::rec_t pos_rec_q;
  rss_pkg::rec_t best_rec_q;
  logic [AW-1:0] best_idx_q;

  rss_pkg::rec_t wr_data;
  logic [AW-1:0] wr_addr;
  logic          wr_en;
  logic          less;

  // write source and address select
  always_comb begin
    wr_en   = 1'b1;
    wr_data = in_rec_i;
    wr_addr = wr_addr_i;
    case (cmd_i.wr_sel)
      rss_pkg::WR_NONE: wr_en = 1'b0;
      rss_pkg::WR_LOAD: wr_data = in_rec_i;
      rss_pkg::WR_BEST: wr_data = best_rec_q;
      rss_pkg::WR_POS: begin
        wr_data = pos_rec_q;
        wr_addr = best_idx_q;
      end
      default: wr_en = 1'b0;
    endcase
  end

  // record memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (cmd_i.rd_en) begin
      rd_q <= mem_q[rd_addr_i];
    end
  end

  // strict less-than keeps the first minimum
  assign less = rd_q.key < best_rec_q.key;

  // pass start and running minimum
  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_pass) begin
      pos_rec_q  <= rd_q;
      best_rec_q <= rd_q;
      best_idx_q <= idx_i;
    end else if (cmd_i.cmp_en && less) begin
      best_rec_q <= rd_q;
      best_idx_q <= idx_i;
    end
  end

  assign rd_rec_o = rd_q;

endmodule

// ----- hdl/rss_ctrl.sv -----
// sequencer for load, selection passes, swaps and emission
module rss_ctrl #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = $clog2(DEPTH),
  parameter int unsigned CW    = $clog2(DEPTH + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic             last_i,
  output logic             busy_o,
  output rss_pkg::dp_cmd_t cmd_o,
  output logic [AW-1:0]    rd_addr_o,
  output logic [AW-1:0]    wr_addr_o,
  output logic [AW-1:0]    idx_o
);

  typedef enum logic [8:0] {
    ST_IDLE     = 9'b000000001,
    ST_PASS_RD  = 9'b000000010,
    ST_PASS_LD  = 9'b000000100,
    ST_SCAN_RD  = 9'b000001000,
    ST_SCAN_CMP = 9'b000010000,
    ST_SWAP_A   = 9'b000100000,
    ST_SWAP_B   = 9'b001000000,
    ST_EMIT_RD  = 9'b010000000,
    ST_EMIT_OUT = 9'b100000000
  } state_e;

  state_e        state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] n_q, n_d;
  logic [AW-1:0] pos_q, pos_d;
  logic [AW-1:0] scan_q, scan_d;

  logic          full;
  logic [CW-1:0] cnt_inc;
  logic          scan_end;

  assign full     = cnt_q == CW'(DEPTH);
  assign cnt_inc  = full ? cnt_q : cnt_q + CW'(1);
  assign scan_end = CW'(scan_q) == n_q - CW'(1);

  // next state and commands
  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    n_d       = n_q;
    pos_d     = pos_q;
    scan_d    = scan_q;
    cmd_o     = '0;
    rd_addr_o = scan_q;
    wr_addr_o = pos_q;
    idx_o     = scan_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          if (!full) begin
            cmd_o.wr_sel = rss_pkg::WR_LOAD;
            wr_addr_o    = cnt_q[AW-1:0];
          end
          if (last_i) begin
            n_d    = cnt_inc;
            cnt_d  = '0;
            pos_d  = '0;
            scan_d = '0;
            state_d = (cnt_inc > CW'(1)) ? ST_PASS_RD : ST_EMIT_RD;
          end else begin
            cnt_d = cnt_inc;
          end
        end
      end
      ST_PASS_RD: begin
        cmd_o.rd_en = 1'b1;
        rd_addr_o   = pos_q;
        state_d     = ST_PASS_LD;
      end
      ST_PASS_LD: begin
        cmd_o.ld_pass = 1'b1;
        idx_o         = pos_q;
        scan_d        = pos_q + AW'(1);
        state_d       = ST_SCAN_RD;
      end
      ST_SCAN_RD: begin
        cmd_o.rd_en = 1'b1;
        state_d     = ST_SCAN_CMP;
      end
      ST_SCAN_CMP: begin
        cmd_o.cmp_en = 1'b1;
        if (scan_end) begin
          state_d = ST_SWAP_A;
        end else begin
          scan_d  = scan_q + AW'(1);
          state_d = ST_SCAN_RD;
        end
      end
      ST_SWAP_A: begin
        cmd_o.wr_sel = rss_pkg::WR_BEST;
        state_d      = ST_SWAP_B;
      end
      ST_SWAP_B: begin
        cmd_o.wr_sel = rss_pkg::WR_POS;
        if (CW'(pos_q) == n_q - CW'(2)) begin
          scan_d  = '0;
          state_d = ST_EMIT_RD;
        end else begin
          pos_d   = pos_q + AW'(1);
          state_d = ST_PASS_RD;
        end
      end
      ST_EMIT_RD: begin
        cmd_o.rd_en = 1'b1;
        state_d     = ST_EMIT_OUT;
      end
      ST_EMIT_OUT: begin
        cmd_o.emit = 1'b1;
        cmd_o.last = scan_end;
        if (scan_end) begin
          state_d = ST_IDLE;
        end else begin
          scan_d  = scan_q + AW'(1);
          state_d = ST_EMIT_RD;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // state and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      n_q     <= '0;
      pos_q   <= '0;
      scan_q  <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      n_q     <= n_d;
      pos_q   <= pos_d;
      scan_q  <= scan_d;
    end
  end

  assign busy_o = state_q != ST_IDLE;

endmodule

// ----- hdl/rss_checker.sv -----
// port-level checks for the record selection sort block
module rss_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start_i,
  input logic busy_o,
  input logic last_i,
  input logic out_valid_o,
  input logic out_last_o
);

  // results only come while the block is busy
  a_valid_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> busy_o)
    else $error("result strobe while idle");

  // result beats are never back to back: a read lies between them
  a_valid_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |=> !out_valid_o)
    else $error("back to back result strobes");

  // the final result ends the set
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_last_o) |=> !busy_o)
    else $error("still busy after final result");

  // a beat without last keeps the block ready
  a_load_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && !last_i) |=> !busy_o)
    else $error("busy after a plain load beat");

  // a last beat starts sort and emission
  a_last_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && last_i) |=> busy_o)
    else $error("last beat did not start the sort");

endmodule

bind record_selection_sort rss_checker u_rss_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .start_i    (start_i),
  .busy_o     (busy_o),
  .last_i     (last_i),
  .out_valid_o(out_valid_o),
  .out_last_o (out_last_o)
);

// ----- tb/record_selection_sort_tb.sv -----
// self-checking testbench for the record selection sort block
module record_selection_sort_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Depth       = 64;
  localparam int unsigned StallLimit  = 20000;
  localparam int unsigned ReportLimit = 10;
  localparam int unsigned RandomBeats = 230;
  localparam int unsigned SettleTail  = 20;

  // one sorted record as it leaves the block
  typedef struct packed {
    rss_pkg::rec_t rec;
    logic          last;
  } sorted_rec_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        start_i;
  logic        busy_o;
  logic [23:0] key_i;
  logic [15:0] record_tag_i;
  logic [9:0]  cur_enroll_i;
  logic [9:0]  max_enroll_i;
  logic [9:0]  waitlist_i;
  logic        online_i;
  logic        last_i;
  logic        out_valid_o;
  logic [23:0] sorted_key_o;
  logic [15:0] out_tag_o;
  logic [9:0]  out_cur_enroll_o;
  logic [9:0]  out_max_enroll_o;
  logic [9:0]  out_waitlist_o;
  logic        out_online_o;
  logic        out_last_o;

  // records collected for the open set and sorted records still to come
  rss_pkg::rec_t held_recs [Depth];
  int unsigned   held_count;
  sorted_rec_t   pending_sorted_q [$];
  int unsigned   fault_count;
  int unsigned   quiet_cycles;
  bit            pauses_on;

  always #2 clk_i = ~clk_i;

  record_selection_sort #(
    .DEPTH(Depth)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_o          (busy_o),
    .key_i           (key_i),
    .record_tag_i    (record_tag_i),
    .cur_enroll_i    (cur_enroll_i),
    .max_enroll_i    (max_enroll_i),
    .waitlist_i      (waitlist_i),
    .online_i        (online_i),
    .last_i          (last_i),
    .out_valid_o     (out_valid_o),
    .sorted_key_o    (sorted_key_o),
    .out_tag_o       (out_tag_o),
    .out_cur_enroll_o(out_cur_enroll_o),
    .out_max_enroll_o(out_max_enroll_o),
    .out_waitlist_o  (out_waitlist_o),
    .out_online_o    (out_online_o),
    .out_last_o      (out_last_o)
  );

  // store one accepted record; on last, selection sort the set and queue it
  function automatic void collect_and_sort(rss_pkg::rec_t r, logic last);
    rss_pkg::rec_t tmp;
    int unsigned   best;
    sorted_rec_t   want;
    if (held_count < Depth) begin
      held_recs[held_count] = r;
      held_count++;
    end
    if (!last) return;
    for (int unsigned pos = 0; pos + 1 < held_count; pos++) begin
      best = pos;
      // first strict minimum wins, swap even with itself
      for (int unsigned scan = pos; scan < held_count; scan++) begin
        if (held_recs[scan].key < held_recs[best].key) best = scan;
      end
      tmp             = held_recs[pos];
      held_recs[pos]  = held_recs[best];
      held_recs[best] = tmp;
    end
    for (int unsigned k = 0; k < held_count; k++) begin
      want.rec  = held_recs[k];
      want.last = (k + 1 == held_count);
      pending_sorted_q.push_back(want);
    end
    held_count = 0;
  endfunction

  function automatic void note_fault(string what, sorted_rec_t want, sorted_rec_t got);
    if (fault_count < ReportLimit) begin
      $display("%t %s", $realtime, what);
      $display("  want key=%h tag=%h cur=%h max=%h wl=%h onl=%b last=%b",
               want.rec.key, want.rec.tag, want.rec.cur_enroll, want.rec.max_enroll,
               want.rec.waitlist, want.rec.online, want.last);
      $display("  got  key=%h tag=%h cur=%h max=%h wl=%h onl=%b last=%b",
               got.rec.key, got.rec.tag, got.rec.cur_enroll, got.rec.max_enroll,
               got.rec.waitlist, got.rec.online, got.last);
    end
    fault_count++;
  endfunction

  // result check, input beat capture and stall watchdog
  always @(posedge clk_i) begin : watch_ports
    sorted_rec_t got;
    sorted_rec_t want;
    if (rst_ni) begin
      if (out_valid_o) begin
        got = {sorted_key_o, out_tag_o, out_cur_enroll_o, out_max_enroll_o,
               out_waitlist_o, out_online_o, out_last_o};
        if (pending_sorted_q.size() == 0) begin
          note_fault("result beat with nothing pending", '0, got);
        end else begin
          want = pending_sorted_q.pop_front();
          if (got.rec.key !== want.rec.key || got.rec.tag !== want.rec.tag ||
              got.rec.cur_enroll !== want.rec.cur_enroll ||
              got.rec.max_enroll !== want.rec.max_enroll ||
              got.rec.waitlist !== want.rec.waitlist ||
              got.rec.online !== want.rec.online || got.last !== want.last) begin
            note_fault("result beat mismatch", want, got);
          end
        end
      end
      if (start_i && !busy_o) begin
        collect_and_sort({key_i, record_tag_i, cur_enroll_i, max_enroll_i,
                          waitlist_i, online_i}, last_i);
      end
      if (out_valid_o || (start_i && !busy_o)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= StallLimit) begin
        $display("record_selection_sort_tb: errors");
        $finish;
      end
    end
  end

  // drive one record beat and hold it until the block takes it
  task automatic send_beat(rss_pkg::rec_t r, logic last);
    while (pauses_on && $urandom_range(99) < 25) begin
      @(negedge clk_i);
      start_i = 1'b0;
      key_i   = 24'($urandom_range(24'hFFFFFF));
      last_i  = 1'($urandom_range(1));
    end
    @(negedge clk_i);
    start_i      = 1'b1;
    key_i        = r.key;
    record_tag_i = r.tag;
    cur_enroll_i = r.cur_enroll;
    max_enroll_i = r.max_enroll;
    waitlist_i   = r.waitlist;
    online_i     = r.online;
    last_i       = last;
    do @(posedge clk_i); while (busy_o);
  endtask

  // keys lean toward duplicates and extremes
  function automatic logic [23:0] pick_key();
    case ($urandom_range(3))
      0:       return 24'($urandom_range(24'hFFFFFF));
      1:       return 24'($urandom_range(3));
      2:       return $urandom_range(1) ? 24'hFFFFFF : 24'h000000;
      default: return 24'hFFFFFF - 24'($urandom_range(3));
    endcase
  endfunction

  function automatic rss_pkg::rec_t random_rec(logic [23:0] key);
    rss_pkg::rec_t r;
    r.key        = key;
    r.tag        = 16'($urandom_range(16'hFFFF));
    r.cur_enroll = 10'($urandom_range(1023));
    r.max_enroll = 10'($urandom_range(1023));
    r.waitlist   = 10'($urandom_range(1023));
    r.online     = 1'($urandom_range(1));
    return r;
  endfunction

  task automatic send_set(int unsigned n);
    for (int unsigned i = 0; i < n; i++) send_beat(random_rec(pick_key()), i + 1 == n);
  endtask

  // sets of one record, all fields at their top and bottom
  task automatic test_lone_record();
    send_beat('1, 1'b1);
    send_beat('0, 1'b1);
  endtask

  task automatic test_extreme_keys();
    logic [23:0] keys [5] = '{24'hFFFFFF, 24'h000000, 24'h800000, 24'h000001, 24'hFFFFFE};
    rss_pkg::rec_t r;
    for (int unsigned i = 0; i < 5; i++) begin
      r     = (i % 2) ? '1 : '0;
      r.key = keys[i];
      r.tag = 16'(i);
      send_beat(r, i == 4);
    end
  endtask

  // duplicate keys, where the swap order breaks stability
  task automatic test_equal_keys();
    logic [23:0] keys [5] = '{24'd7, 24'd3, 24'd7, 24'd3, 24'd7};
    rss_pkg::rec_t r;
    for (int unsigned i = 0; i < 5; i++) begin
      r     = random_rec(keys[i]);
      r.tag = 16'(i + 1);
      send_beat(r, i == 4);
    end
    for (int unsigned i = 0; i < 4; i++) begin
      r     = random_rec(24'h123456);
      r.tag = 16'(i + 16);
      send_beat(r, i == 3);
    end
  endtask

  task automatic test_ordered_sets();
    for (int unsigned i = 0; i < 4; i++) send_beat(random_rec(24'(i + 1)), i == 3);
    for (int unsigned i = 0; i < 4; i++) send_beat(random_rec(24'(40 - 10 * i)), i == 3);
  endtask

  // exactly DEPTH records, last on the final stored one, no pauses
  task automatic test_full_set();
    pauses_on = 1'b0;
    send_set(Depth);
    pauses_on = 1'b1;
  endtask

  // records past DEPTH are dropped, a dropped last still starts the sort
  task automatic test_overflow();
    for (int unsigned i = 0; i < Depth + 4; i++) send_beat(random_rec(pick_key()), i == Depth + 3);
    for (int unsigned i = 0; i < Depth + 1; i++) send_beat(random_rec(pick_key()), i == Depth);
  endtask

  // random sets, mostly small, a long stretch first without pauses
  task automatic test_random_sets();
    int unsigned sent;
    int unsigned n;
    sent      = 0;
    pauses_on = 1'b0;
    while (sent < RandomBeats) begin
      if (sent > 100) pauses_on = 1'b1;
      n = ($urandom_range(19) == 0) ? $urandom_range(Depth, 13) : $urandom_range(12, 1);
      send_set(n);
      sent += n;
    end
  endtask

  initial begin
    rst_ni       = 1'b0;
    start_i      = 1'b0;
    key_i        = '0;
    record_tag_i = '0;
    cur_enroll_i = '0;
    max_enroll_i = '0;
    waitlist_i   = '0;
    online_i     = 1'b0;
    last_i       = 1'b0;
    held_count   = 0;
    fault_count  = 0;
    quiet_cycles = 0;
    pauses_on    = 1'b1;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    test_lone_record();
    test_extreme_keys();
    test_equal_keys();
    test_ordered_sets();
    test_full_set();
    test_overflow();
    test_random_sets();

    // drain the last set, then settle
    @(negedge clk_i);
    start_i = 1'b0;
    while (pending_sorted_q.size() != 0) @(negedge clk_i);
    repeat (SettleTail) @(negedge clk_i);
    if (fault_count == 0) begin
      $display("record_selection_sort_tb: clean");
    end else begin
      $display("record_selection_sort_tb: errors");
    end
    $finish;
  end

endmodule
